@@ hw/rtl/hq_pkg.sv @@
`default_nettype none

package hq_pkg;

  // Every reported bin index is carried in this many bits.
  localparam int unsigned OUT_IDX_W = 10;

  // Stream payload widths.
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 64;

  // Decile bound slack in tenths: floor(y/10) <= a holds while y <= 10a + 9.
  localparam int unsigned DEC_SLACK = 9;

  // Target lanes, in the order the scan keeps them.
  localparam int unsigned NUM_TGT   = 5;
  localparam int unsigned TGT_LQ    = 0;
  localparam int unsigned TGT_UQ    = 1;
  localparam int unsigned TGT_P10   = 2;
  localparam int unsigned TGT_P90   = 3;
  localparam int unsigned TGT_MED   = 4;

endpackage

`default_nettype wire

@@ hw/rtl/histogram_quantiles.sv @@
`default_nettype none
// Loading: one bin per cycle, the input stays ready until the request with tlast.
// After tlast: a drain until the product pipeline is empty, clog2(NUM_BINS) mean
// divide steps, a scan of the bins held (one bin store read a cycle) and an emit
// step that posts the result, held while the output register is still full.
// Reset (rst_ni low, asynchronous) empties the histogram; the bin store is not
// cleared, only bins loaded for the current one are read.
module histogram_quantiles
  import hq_pkg::*;
#(
  parameter int unsigned NUM_BINS   = 1024,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // s_axis_tdata_i: [31:0] bin_count
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                   s_axis_tlast_i,   // last_bin
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // m_axis_tdata_o: [9:0] mean_bin, [19:10] lower_quartile, [29:20] upper_quartile,
  // [39:30] tenth_percentile, [49:40] ninetieth_percentile, [59:50] median_bin,
  // [63:60] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                        m_axis_tuser_o,   // [0] bins_dropped
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i
);

  // Widths: bin index, bins-held count, total count, weighted sum, 9*total.
  localparam int unsigned IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned LD_W   = IDX_W + 1;
  localparam int unsigned TOT_W  = COUNT_BITS + IDX_W;
  localparam int unsigned WS_W   = COUNT_BITS + 2 * IDX_W;
  localparam int unsigned PRD_W  = COUNT_BITS + IDX_W;
  localparam int unsigned T9_W   = TOT_W + 4;
  localparam int unsigned STEP_W = $clog2(IDX_W + 1);

  localparam logic [T9_W-1:0] SLACK_X = T9_W'(DEC_SLACK);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_DIV,
    ST_SCAN,
    ST_EMIT
  } state_e;

  function automatic logic [OUT_IDX_W-1:0] to_out(input logic [IDX_W-1:0] v);
    logic [IDX_W+OUT_IDX_W-1:0] w;
    w = {{OUT_IDX_W{1'b0}}, v};
    return w[OUT_IDX_W-1:0];
  endfunction

  // 10*v by shift and add
  function automatic logic [T9_W-1:0] ten_x(input logic [T9_W-1:0] v);
    return {v[T9_W-4:0], 3'b000} + {v[T9_W-2:0], 1'b0};
  endfunction

  state_e state_q;

  // Histogram bookkeeping
  logic [LD_W-1:0]       loaded_q;
  logic [TOT_W-1:0]      total_q;
  logic [WS_W-1:0]       wsum_q;
  logic                  ovf_q;

  // Multiply pipeline for index * count
  logic                  mul_v_q;
  logic [IDX_W-1:0]      mul_idx_q;
  logic [COUNT_BITS-1:0] mul_cnt_q;
  logic                  prod_v_q;
  logic [PRD_W-1:0]      prod_q;

  // Divide unit: restoring division for the mean
  logic [STEP_W-1:0]     step_q;
  logic [WS_W-1:0]       rem_q;
  logic [WS_W-1:0]       dv_q;
  logic [IDX_W-1:0]      mq_q;

  // Scan pass, all bounds in tenths of a count. A lane picks the bin when
  // 10*before <= tgt_q and tgt_end_q <= 10*after. Exact targets t use 10t on
  // both sides; a decile floor(y/10) uses y and y - 9 (floored at zero).
  logic [T9_W-1:0]       tgt_q     [NUM_TGT];
  logic [T9_W-1:0]       tgt_end_q [NUM_TGT];
  logic [IDX_W-1:0]      pick_q [NUM_TGT];
  logic [LD_W-1:0]       addr_q;
  logic                  rd_v_q;
  logic [IDX_W-1:0]      rd_i_q;
  logic [T9_W-1:0]       before10_q;

  // Bin store
  logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rdata_q;

  // Output register
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_user_q;
  logic                   out_valid_q;

  // Combinational helpers
  logic                  accept;
  logic                  full;
  logic                  keep;
  logic [COUNT_BITS-1:0] cnt_in;
  logic [IN_TDATA_W+COUNT_BITS-1:0] cnt_ext;
  logic [WS_W:0]         dv_init_w;
  logic [TOT_W+1:0]      three_t;
  logic [T9_W-1:0]       nine_t;
  logic [T9_W-1:0]       tot_x;
  logic [T9_W-1:0]       lq10, uq10, med10;
  logic [T9_W-1:0]       p10_end, p90_end;
  logic                  mge;
  logic [IDX_W:0]        mq_w;
  logic [T9_W-1:0]       after10;
  logic [IDX_W-1:0]      mean_idx;

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign full            = (loaded_q == LD_W'(NUM_BINS));
  assign keep            = accept & ~full;

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tvalid_o = out_valid_q;

  always_comb begin
    // only the low COUNT_BITS of the count are kept
    cnt_ext   = {{COUNT_BITS{1'b0}}, s_axis_tdata_i};
    cnt_in    = cnt_ext[COUNT_BITS-1:0];
    // first mean divisor: total << (IDX_W-1)
    dv_init_w = {1'b0, total_q, {IDX_W{1'b0}}} >> 1;
    three_t   = {2'b00, total_q} + {1'b0, total_q, 1'b0};
    nine_t    = {1'b0, total_q, 3'b000} + {4'b0000, total_q};
    tot_x     = {4'b0000, total_q};
    // exact targets scaled to tenths
    lq10      = ten_x({6'b000000, total_q[TOT_W-1:2]});
    uq10      = ten_x({4'b0000, three_t[TOT_W+1:2]});
    med10     = ten_x({5'b00000, total_q[TOT_W-1:1]});
    // decile upper-side bounds
    p10_end   = (tot_x >= SLACK_X) ? tot_x - SLACK_X : '0;
    p90_end   = (nine_t >= SLACK_X) ? nine_t - SLACK_X : '0;
    // mean: one restoring step
    mge       = (rem_q >= dv_q);
    mq_w      = {mq_q, mge};
    // scan: end of the bin just read, in tenths
    after10   = before10_q + {{(IDX_W+1){1'b0}}, rdata_q, 3'b000}
                           + {{(IDX_W+3){1'b0}}, rdata_q, 1'b0};
    mean_idx  = (total_q == '0) ? '0 : mq_q;
  end

  // Bin store: written while loading, read during the scan.
  always_ff @(posedge clk_i) begin
    if (keep) begin
      bin_mem[loaded_q[IDX_W-1:0]] <= cnt_in;
    end
    rdata_q <= bin_mem[addr_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      loaded_q    <= '0;
      total_q     <= '0;
      wsum_q      <= '0;
      ovf_q       <= 1'b0;
      mul_v_q     <= 1'b0;
      prod_v_q    <= 1'b0;
      step_q      <= '0;
      addr_q      <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // product pipeline runs freely: request registers, then prod_q, then the sum
      mul_v_q  <= keep;
      prod_v_q <= mul_v_q;
      prod_q   <= {{COUNT_BITS{1'b0}}, mul_idx_q} * {{IDX_W{1'b0}}, mul_cnt_q};
      if (prod_v_q) begin
        wsum_q <= wsum_q + {{IDX_W{1'b0}}, prod_q};
      end

      // emit reloads the register itself
      if (out_valid_q && m_axis_tready_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_LOAD: begin
          if (keep) begin
            total_q   <= total_q + {{IDX_W{1'b0}}, cnt_in};
            mul_idx_q <= loaded_q[IDX_W-1:0];
            mul_cnt_q <= cnt_in;
            loaded_q  <= loaded_q + LD_W'(1);
          end
          if (accept && full) begin
            ovf_q <= 1'b1;
          end
          if (accept && s_axis_tlast_i) begin
            state_q <= ST_DRAIN;
          end
        end

        ST_DRAIN: begin
          if (!mul_v_q && !prod_v_q) begin
            rem_q              <= wsum_q;
            dv_q               <= dv_init_w[WS_W-1:0];
            mq_q               <= '0;
            step_q             <= '0;
            tgt_q[TGT_LQ]      <= lq10;
            tgt_q[TGT_UQ]      <= uq10;
            tgt_q[TGT_P10]     <= tot_x;
            tgt_q[TGT_P90]     <= nine_t;
            tgt_q[TGT_MED]     <= med10;
            tgt_end_q[TGT_LQ]  <= lq10;
            tgt_end_q[TGT_UQ]  <= uq10;
            tgt_end_q[TGT_P10] <= p10_end;
            tgt_end_q[TGT_P90] <= p90_end;
            tgt_end_q[TGT_MED] <= med10;
            state_q            <= ST_DIV;
          end
        end

        ST_DIV: begin
          // mean quotient is below NUM_BINS, so IDX_W steps suffice
          if (mge) begin
            rem_q <= rem_q - dv_q;
          end
          dv_q   <= dv_q >> 1;
          mq_q   <= mq_w[IDX_W-1:0];
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(IDX_W - 1)) begin
            addr_q     <= '0;
            rd_v_q     <= 1'b0;
            before10_q <= '0;
            for (int k = 0; k < NUM_TGT; k++) begin
              pick_q[k] <= '0;
            end
            state_q <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // issue one read a cycle, evaluate it the next
          if (addr_q < loaded_q) begin
            rd_v_q <= 1'b1;
            rd_i_q <= addr_q[IDX_W-1:0];
            addr_q <= addr_q + LD_W'(1);
          end else begin
            rd_v_q <= 1'b0;
          end
          if (rd_v_q) begin
            before10_q <= after10;
            // inclusive range, so a later bin on a boundary overrides
            for (int k = 0; k < NUM_TGT; k++) begin
              if (before10_q <= tgt_q[k] && tgt_end_q[k] <= after10) begin
                pick_q[k] <= rd_i_q;
              end
            end
          end
          if (addr_q == loaded_q && !rd_v_q) begin
            state_q <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          // wait for a free output register, then start the next histogram
          if (!out_valid_q || m_axis_tready_i) begin
            out_data_q  <= {4'b0000,
                            to_out(pick_q[TGT_MED]),
                            to_out(pick_q[TGT_P90]),
                            to_out(pick_q[TGT_P10]),
                            to_out(pick_q[TGT_UQ]),
                            to_out(pick_q[TGT_LQ]),
                            to_out(mean_idx)};
            out_user_q  <= ovf_q;
            out_valid_q <= 1'b1;
            loaded_q    <= '0;
            total_q     <= '0;
            wsum_q      <= '0;
            ovf_q       <= 1'b0;
            state_q     <= ST_LOAD;
          end
        end

        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  // Bin store never holds more than its depth.
  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= LD_W'(NUM_BINS))
    else $error("bins held exceed store depth");

  // Division starts only once the weighted sum has settled.
  a_div_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (!mul_v_q && !prod_v_q))
    else $error("divide started with products in flight");

  // Scan only evaluates bins of the current histogram.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && rd_v_q) |-> ({1'b0, rd_i_q} < loaded_q))
    else $error("scan read beyond loaded bins");

  // A new result appears only from the emit step.
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result posted outside emit");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;
  import hq_pkg::*;

  localparam int unsigned STORE_BINS  = 1024;     // matches the default NUM_BINS
  localparam int unsigned RAND_ITEMS  = 1900;
  localparam int unsigned TAIL_CYCLES = 200;      // well past divide + scan of a small set
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic        last;
    logic [31:0] count;
  } bin_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] mean;
    logic [OUT_IDX_W-1:0] lq;
    logic [OUT_IDX_W-1:0] uq;
    logic [OUT_IDX_W-1:0] p10;
    logic [OUT_IDX_W-1:0] p90;
    logic [OUT_IDX_W-1:0] med;
    logic                 dropped;
  } hist_stats_t;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tlast  = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;

  histogram_quantiles dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  always #10 clk_i = ~clk_i;

  // bins waiting to be sent, stats still owed by the block
  bin_item_t   bin_feed_q[$];
  hist_stats_t stats_due_q[$];

  // shadow of the histogram being loaded
  logic [31:0] bin_mem [STORE_BINS];
  int unsigned bins_held = 0;
  bit          drop_flag = 1'b0;

  int unsigned feed_total  = 0;
  int unsigned taken_cnt   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned feed_gap    = 0;
  int unsigned sink_stall  = 0;
  logic [31:0] cyc_cnt     = '0;
  logic        in_fire     = 1'b0;
  bin_item_t   cur_bin;

  // Mean and the five quantile bins of the held histogram. A bin's range is
  // [count before it, count through it], inclusive on both ends, and the last
  // matching bin wins, so trailing empty bins on a boundary take the pick.
  function automatic hist_stats_t histogram_stats();
    logic [63:0]          total, wsum, lo, hi;
    logic [63:0]          tq   [NUM_TGT];
    logic [OUT_IDX_W-1:0] pick [NUM_TGT];
    hist_stats_t          r;
    total = '0;
    wsum  = '0;
    for (int i = 0; i < int'(bins_held); i++) begin
      total += 64'(bin_mem[i]);
      wsum  += 64'(i) * 64'(bin_mem[i]);
    end
    // total < 2^42, so the x3 and x9 products cannot wrap
    tq[TGT_LQ]  = total / 4;
    tq[TGT_UQ]  = (total * 3) / 4;
    tq[TGT_P10] = total / 10;
    tq[TGT_P90] = (total * 9) / 10;
    tq[TGT_MED] = total / 2;
    lo = '0;
    for (int k = 0; k < int'(NUM_TGT); k++) pick[k] = '0;
    for (int i = 0; i < int'(bins_held); i++) begin
      hi = lo + 64'(bin_mem[i]);
      for (int k = 0; k < int'(NUM_TGT); k++)
        if (tq[k] >= lo && tq[k] <= hi) pick[k] = OUT_IDX_W'(i);
      lo = hi;
    end
    r.mean    = (total == 0) ? '0 : OUT_IDX_W'(wsum / total);
    r.lq      = pick[TGT_LQ];
    r.uq      = pick[TGT_UQ];
    r.p10     = pick[TGT_P10];
    r.p90     = pick[TGT_P90];
    r.med     = pick[TGT_MED];
    r.dropped = drop_flag;
    return r;
  endfunction

  // fold one accepted request into the shadow; tlast closes the histogram,
  // even when that bin itself is dropped for lack of room
  task automatic take_bin(input bin_item_t it);
    if (bins_held < STORE_BINS) begin
      bin_mem[bins_held] = it.count;
      bins_held++;
    end else begin
      drop_flag = 1'b1;
    end
    if (it.last) begin
      stats_due_q.push_back(histogram_stats());
      bins_held = 0;
      drop_flag = 1'b0;
    end
  endtask

  task automatic report_bad(input string msg);
    if (mismatch_cnt < 10) $display("%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic push_bin(input logic [31:0] count, input logic last);
    bin_item_t it;
    it.count = count;
    it.last  = last;
    bin_feed_q.push_back(it);
  endtask

  // zeros and tiny counts make boundary hits likely, full-range values
  // toggle every bit and drive the wide sums
  function automatic logic [31:0] rand_count();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) return '0;
    if (sel < 60) return 32'($urandom_range(1, 20));
    if (sel < 85) return $urandom;
    if (sel < 93) return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    return 32'h1 << $urandom_range(0, 31);
  endfunction

  task automatic add_hist(input int unsigned n, input bit all_zero);
    for (int unsigned j = 0; j < n; j++)
      push_bin(all_zero ? 32'h0 : rand_count(), j == n - 1);
  endtask

  // gap length: mostly none or short, now and then long; a quiet window
  // while cyc_cnt[9:8] is 3 runs at full rate on both sides
  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (cyc_cnt[9:8] == 2'b11) return 0;
    sel = $urandom_range(99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver: new request at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid || in_fire) begin
        if (feed_gap > 0 || bin_feed_q.size() == 0) begin
          s_tvalid <= 1'b0;
          if (feed_gap > 0) feed_gap--;
        end else begin
          cur_bin  = bin_feed_q.pop_front();
          s_tdata  <= cur_bin.count;
          s_tlast  <= cur_bin.last;
          s_tvalid <= 1'b1;
          feed_gap = pick_gap();
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_stall > 0) begin
        m_tready <= 1'b0;
        sink_stall--;
      end else begin
        m_tready <= 1'b1;
        sink_stall = pick_gap();
      end
    end
  end

  // monitor: requests feed the shadow, results are checked in order
  always @(posedge clk_i) begin
    bin_item_t   it;
    hist_stats_t got, want;
    if (rst_ni) begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        it.count = s_tdata[31:0];
        it.last  = s_tlast;
        take_bin(it);
        taken_cnt++;
      end
      if (m_tvalid && m_tready) begin
        got.mean    = m_tdata[9:0];
        got.lq      = m_tdata[19:10];
        got.uq      = m_tdata[29:20];
        got.p10     = m_tdata[39:30];
        got.p90     = m_tdata[49:40];
        got.med     = m_tdata[59:50];
        got.dropped = m_tuser;
        if (stats_due_q.size() == 0) begin
          report_bad($sformatf("result with none pending: mean %0d lq %0d uq %0d",
                               got.mean, got.lq, got.uq));
        end else begin
          want = stats_due_q.pop_front();
          if (got !== want)
            report_bad($sformatf({"mismatch exp mean %0d lq %0d uq %0d p10 %0d p90 %0d ",
                                  "med %0d drop %0b / got %0d %0d %0d %0d %0d %0d %0b"},
                                 want.mean, want.lq, want.uq, want.p10, want.p90,
                                 want.med, want.dropped, got.mean, got.lq, got.uq,
                                 got.p10, got.p90, got.med, got.dropped));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("histogram_quantiles verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned rand_items, n, big_at;
    bit          big_done;

    // empty histogram, one bin: everything lands on bin 0
    push_bin(32'h0, 1'b1);
    // empty histogram, three bins: every quantile is the last bin
    push_bin(32'h0, 1'b0);
    push_bin(32'h0, 1'b0);
    push_bin(32'h0, 1'b1);
    // single full-scale bin
    push_bin(32'hFFFF_FFFF, 1'b1);
    // full-scale counts in every bin, widest sums for a short set
    for (int j = 0; j < 4; j++) push_bin(32'hFFFF_FFFF, j == 3);
    // empty bins sitting on a boundary must win the pick
    push_bin(32'd0, 1'b0);
    push_bin(32'd5, 1'b0);
    push_bin(32'd0, 1'b0);
    push_bin(32'd0, 1'b0);
    push_bin(32'd5, 1'b0);
    push_bin(32'd0, 1'b1);
    // mass at both ends, hollow middle
    push_bin(32'd1, 1'b0);
    push_bin(32'd0, 1'b0);
    push_bin(32'd0, 1'b0);
    push_bin(32'd0, 1'b0);
    push_bin(32'd1, 1'b1);
    push_bin(32'd7, 1'b0);
    push_bin(32'd0, 1'b0);
    push_bin(32'd3, 1'b1);

    // random histograms, one of them overrunning the store so the trailing
    // bins (tlast among them) are dropped and flagged
    rand_items = 0;
    big_done   = 1'b0;
    big_at     = $urandom_range(200, 800);
    while (rand_items < RAND_ITEMS) begin
      if (!big_done && rand_items >= big_at) begin
        n        = STORE_BINS + $urandom_range(1, 4);
        big_done = 1'b1;
        add_hist(n, 1'b0);
      end else begin
        case ($urandom_range(19))
          0:       n = $urandom_range(41, 200);
          1, 2, 3,
          4, 5:    n = $urandom_range(9, 40);
          default: n = $urandom_range(1, 8);
        endcase
        add_hist(n, $urandom_range(19) == 0);
      end
      rand_items += n;
    end
    feed_total = bin_feed_q.size();

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (!(taken_cnt == feed_total && stats_due_q.size() == 0));
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("histogram_quantiles verification clean");
    end else begin
      $display("histogram_quantiles verification failed");
    end
    $finish;
  end

endmodule

@@ histogram_quantiles.f @@
hw/rtl/hq_pkg.sv
hw/rtl/histogram_quantiles.sv
tb/sv/tb.sv
